/* rtl/core/ipv4hc_pkg.sv */
`default_nettype none

package ipv4hc_pkg;

  localparam int unsigned HdrWords = 10;
  localparam int unsigned CountW   = 4;

  localparam logic [3:0]  IpVersion = 4'd4;
  localparam logic [3:0]  IpIhl     = 4'd5;
  localparam logic [7:0]  IpTos     = 8'h00;
  localparam logic [15:0] HdrBytes  = 16'd20;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // header word positions that matter
  localparam logic [CountW-1:0] PosVerTos   = 4'd0;
  localparam logic [CountW-1:0] PosTotLen   = 4'd1;
  localparam logic [CountW-1:0] PosFlags    = 4'd3;
  localparam logic [CountW-1:0] PosProto    = 4'd4;
  localparam logic [CountW-1:0] PosChecksum = 4'd5;
  localparam logic [CountW-1:0] PosSrcHi    = 4'd6;
  localparam logic [CountW-1:0] PosSrcLo    = 4'd7;
  localparam logic [CountW-1:0] PosDstHi    = 4'd8;
  localparam logic [CountW-1:0] PosLast     = 4'd9;
  localparam logic [CountW-1:0] PosDone     = 4'd10;

  typedef enum logic [3:0] {
    REASON_NONE      = 4'd0,
    REASON_VERSION   = 4'd1,
    REASON_IHL       = 4'd2,
    REASON_TOS       = 4'd3,
    REASON_LENGTH    = 4'd4,
    REASON_RESERVED  = 4'd5,
    REASON_FRAGMENT  = 4'd6,
    REASON_CHECKSUM  = 4'd7,
    REASON_DEST      = 4'd8
  } reason_e;

  typedef enum logic [1:0] {
    CLASS_ICMP    = 2'd0,
    CLASS_UDP     = 2'd1,
    CLASS_UNKNOWN = 2'd2
  } proto_class_e;

endpackage

`default_nettype wire

/* rtl/core/ipv4_header_check_classify.sv */
// IPv4 receive header check and classifier.
// Input channel (in_valid_i / in_stall_o): one 16-bit header word per item,
// first_word_i marks word 0 and carries frame_bytes_i. Ten words make a header.
// Output channel (out_valid_o / out_stall_i): one verdict item per header, on
// the tenth word: accepted flag, first failing check, protocol class, source
// address and payload size (frame size less 20, floored at zero).
// local_address_i is written when local_address_we_i is high; the user must write
// it only while idle, as the block itself does not enforce this.
// Throughput: one word per cycle while the receiver does not stall. Each word
// passes an input register and then one combinational step (running ones-complement
// add with fold, field capture, verdict) into the output register.
// When the receiver stalls, the verdict holds in the output register, the input
// register still takes one more word if it is empty, and then in_stall_o rises.
// Reset clears the word count, the running sum, all captured fields, the
// local address and both valid flags. Unmarked words after reset are taken
// at the current count; words after the tenth are dropped until a marked word.
`default_nettype none

module ipv4_header_check_classify
  import ipv4hc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        local_address_we_i,
  input  wire logic [31:0] local_address_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] header_word_i,
  input  wire logic        first_word_i,
  input  wire logic [15:0] frame_bytes_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic [3:0]       reject_reason_o,
  output logic [1:0]       protocol_class_o,
  output logic [31:0]      source_address_o,
  output logic [15:0]      payload_bytes_o
);

  // input register
  logic        in_valid_q, in_valid_d;
  logic [15:0] word_q;
  logic        first_q;
  logic [15:0] frame_in_q;

  // header state
  logic [CountW-1:0] count_q, count_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] ver_tos_q, ver_tos_d;
  logic [15:0] tot_len_q, tot_len_d;
  logic [15:0] flags_q, flags_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] src_hi_q, src_hi_d;
  logic [15:0] src_lo_q, src_lo_d;
  logic [15:0] dst_hi_q, dst_hi_d;
  logic [15:0] frame_q, frame_d;
  logic [15:0] rx_csum_q, rx_csum_d;
  logic [31:0] local_addr_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        accepted_q;
  reason_e     reason_q, reason_d;
  logic [1:0]  class_q, class_d;
  logic [31:0] src_out_q, src_out_d;
  logic [15:0] payload_q, payload_d;

  logic              out_free;
  logic              proc;
  logic              in_load;
  logic [CountW-1:0] pos;
  logic [15:0]       sum_base;
  logic [16:0]       sum_raw;
  logic [15:0]       sum_fold;
  logic              in_range;
  logic              emit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  assign pos      = first_q ? PosVerTos : count_q;
  assign sum_base = (pos == PosVerTos) ? 16'd0 : sum_q;
  // end-around carry never overflows again
  assign sum_raw  = {1'b0, sum_base} + {1'b0, word_q};
  assign sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};
  assign in_range = (pos < PosDone);
  assign emit     = proc && (pos == PosLast);

  always_comb begin
    count_d   = count_q;
    sum_d     = sum_q;
    ver_tos_d = ver_tos_q;
    tot_len_d = tot_len_q;
    flags_d   = flags_q;
    proto_d   = proto_q;
    src_hi_d  = src_hi_q;
    src_lo_d  = src_lo_q;
    dst_hi_d  = dst_hi_q;
    frame_d   = frame_q;
    rx_csum_d = rx_csum_q;
    if (proc) begin
      if (first_q) begin
        frame_d = frame_in_q;
      end
      if (in_range) begin
        if (pos == PosChecksum) begin
          rx_csum_d = word_q;
          sum_d     = sum_base;
        end else begin
          sum_d = sum_fold;
        end
        unique case (pos)
          PosVerTos: ver_tos_d = word_q;
          PosTotLen: tot_len_d = word_q;
          PosFlags:  flags_d   = word_q;
          PosProto:  proto_d   = word_q[7:0];
          PosSrcHi:  src_hi_d  = word_q;
          PosSrcLo:  src_lo_d  = word_q;
          PosDstHi:  dst_hi_d  = word_q;
          default: ;
        endcase
        count_d = pos + 4'd1;
      end
    end
  end

  // verdict, valid only on the last header word
  always_comb begin
    priority if (ver_tos_q[15:12] != IpVersion) begin
      reason_d = REASON_VERSION;
    end else if (ver_tos_q[11:8] != IpIhl) begin
      reason_d = REASON_IHL;
    end else if (ver_tos_q[7:0] != IpTos) begin
      reason_d = REASON_TOS;
    end else if (tot_len_q < HdrBytes) begin
      reason_d = REASON_LENGTH;
    end else if (flags_q[15]) begin
      reason_d = REASON_RESERVED;
    end else if (flags_q[13] || (flags_q[12:0] != 13'd0)) begin
      reason_d = REASON_FRAGMENT;
    end else if (~sum_fold != rx_csum_q) begin
      reason_d = REASON_CHECKSUM;
    end else if ({dst_hi_q, word_q} != local_addr_q) begin
      reason_d = REASON_DEST;
    end else begin
      reason_d = REASON_NONE;
    end

    priority if (proto_q == ProtoIcmp) begin
      class_d = CLASS_ICMP;
    end else if (proto_q == ProtoUdp) begin
      class_d = CLASS_UDP;
    end else begin
      class_d = CLASS_UNKNOWN;
    end

    src_out_d = {src_hi_q, src_lo_q};
    payload_d = (frame_q >= HdrBytes) ? (frame_q - HdrBytes) : 16'd0;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      sum_q        <= '0;
      ver_tos_q    <= '0;
      tot_len_q    <= '0;
      flags_q      <= '0;
      proto_q      <= '0;
      src_hi_q     <= '0;
      src_lo_q     <= '0;
      dst_hi_q     <= '0;
      frame_q      <= '0;
      rx_csum_q    <= '0;
      local_addr_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      ver_tos_q   <= ver_tos_d;
      tot_len_q   <= tot_len_d;
      flags_q     <= flags_d;
      proto_q     <= proto_d;
      src_hi_q    <= src_hi_d;
      src_lo_q    <= src_lo_d;
      dst_hi_q    <= dst_hi_d;
      frame_q     <= frame_d;
      rx_csum_q   <= rx_csum_d;
      if (local_address_we_i) begin
        local_addr_q <= local_address_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      word_q     <= header_word_i;
      first_q    <= first_word_i;
      frame_in_q <= frame_bytes_i;
    end
    if (emit) begin
      accepted_q <= (reason_d == REASON_NONE);
      reason_q   <= reason_d;
      class_q    <= class_d;
      src_out_q  <= src_out_d;
      payload_q  <= payload_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = accepted_q;
  assign reject_reason_o  = reason_q;
  assign protocol_class_o = class_q;
  assign source_address_o = src_out_q;
  assign payload_bytes_o  = payload_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PosDone)
    else $error("word count beyond header length");

  a_accept_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (reject_reason_o == REASON_NONE)))
    else $error("accepted flag disagrees with reject reason");

  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && (count_q == PosDone))
    else $error("verdict not tied to tenth header word");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked verdict");

endmodule

`default_nettype wire
